### rtl/msbp_pkg.sv
`timescale 1ns / 1ps

package msbp_pkg;

    localparam int MAX_CODE_BITS   = 16;
    localparam int COUNT_W         = 5;
    localparam int CODE_W          = 16;
    localparam int BYTE_W          = 8;
    localparam int FREE_W          = 4;
    localparam int TOTAL_W         = 32;
    localparam int EMIT_W          = 2;
    localparam int S_TDATA_W       = 24;
    localparam int M_TDATA_W       = 56;

    localparam logic [FREE_W-1:0]  FREE_EMPTY = 4'd8;
    localparam logic [TOTAL_W-1:0] LIMIT_RESET = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [BYTE_W-1:0]  pending;
        logic [FREE_W-1:0]  free_pos;
        logic [TOTAL_W-1:0] written;
        logic               overflow;
    } pack_state_t;

    typedef struct packed {
        logic [EMIT_W-1:0]  bytes_emitted;
        logic [BYTE_W-1:0]  first_byte;
        logic [BYTE_W-1:0]  second_byte;
        logic               limit_hit;
        logic [TOTAL_W-1:0] bytes_total;
    } pack_result_t;

endpackage

### rtl/msbp_core.sv
`timescale 1ns / 1ps

module msbp_core (
    input  msbp_pkg::pack_state_t            state_i,
    input  logic [msbp_pkg::TOTAL_W-1:0]     size_limit_i,
    input  logic [msbp_pkg::COUNT_W-1:0]     bit_count_i,
    input  logic [msbp_pkg::CODE_W-1:0]      code_value_i,
    output msbp_pkg::pack_state_t            state_o,
    output msbp_pkg::pack_result_t           result_o
);
    import msbp_pkg::*;

    logic [COUNT_W-1:0]   n_clip;
    logic [CODE_W:0]      mask_w;
    logic [CODE_W-1:0]    x_val;
    logic [FREE_W-1:0]    fp_cur;
    logic [FREE_W-1:0]    fp_new;
    logic [COUNT_W-1:0]   rem;
    logic [CODE_W-1:0]    x_hi;
    logic [CODE_W-1:0]    x_lo;
    logic [CODE_W+BYTE_W-1:0] x_shl;
    logic [BYTE_W-1:0]    byte1;
    logic [BYTE_W-1:0]    byte2;
    logic [BYTE_W-1:0]    pending_new;
    logic                 try1;
    logic                 try2;
    logic                 ok1;
    logic                 ok2;
    logic [TOTAL_W-1:0]   written_1;

    always_comb begin
        n_clip = (bit_count_i > COUNT_W'(MAX_CODE_BITS)) ? COUNT_W'(MAX_CODE_BITS)
                                                         : bit_count_i;
        mask_w = ((CODE_W+1)'(1) << n_clip) - (CODE_W+1)'(1);
        x_val  = code_value_i & mask_w[CODE_W-1:0];
        fp_cur = (state_i.free_pos == '0 || state_i.free_pos > FREE_EMPTY)
                 ? FREE_EMPTY : state_i.free_pos;

        rem    = n_clip - {1'b0, fp_cur};
        x_hi   = x_val >> rem;
        x_lo   = x_val >> (rem - COUNT_W'(BYTE_W));
        byte1  = state_i.pending | x_hi[BYTE_W-1:0];
        byte2  = x_lo[BYTE_W-1:0];
        try1   = 1'b0;
        try2   = 1'b0;

        if (n_clip < {1'b0, fp_cur}) begin
            fp_new = fp_cur - n_clip[FREE_W-1:0];
        end else if (rem < COUNT_W'(BYTE_W)) begin
            try1   = 1'b1;
            fp_new = FREE_W'(COUNT_W'(BYTE_W) - rem);
        end else begin
            try1   = 1'b1;
            try2   = 1'b1;
            fp_new = FREE_W'(COUNT_W'(2 * BYTE_W) - rem);
        end

        // Code bits that did not complete a byte are left-aligned into the pending byte.
        x_shl = {{BYTE_W{1'b0}}, x_val} << fp_new;
        if (try1) begin
            pending_new = x_shl[BYTE_W-1:0];
        end else begin
            pending_new = state_i.pending | x_shl[BYTE_W-1:0];
        end

        // The second byte sees the count as already bumped by the first.
        ok1       = try1 && (state_i.written < size_limit_i);
        written_1 = state_i.written + TOTAL_W'(ok1);
        ok2       = try2 && (written_1 < size_limit_i);

        state_o.pending  = pending_new;
        state_o.free_pos = fp_new;
        state_o.written  = written_1 + TOTAL_W'(ok2);
        state_o.overflow = state_i.overflow | (try1 & ~ok1) | (try2 & ~ok2);

        result_o.bytes_emitted = EMIT_W'(ok1) + EMIT_W'(ok2);
        result_o.first_byte    = ok1 ? byte1 : '0;
        result_o.second_byte   = ok2 ? byte2 : '0;
        result_o.limit_hit     = state_o.overflow;
        result_o.bytes_total   = state_o.written;
    end

endmodule

### rtl/msb_bit_field_packer.sv
`timescale 1ns / 1ps

// MSB-first variable-length bit packer.
// Input channel s_*: each item carries a bit count (0..16, larger counts are
// clipped to 16) and a right-aligned code value; its low bits are appended to
// the byte stream, most significant bit first.
// Result channel m_*: exactly one item per input item, giving how many bytes
// (0..2) the input completed, those bytes in order, the sticky limit flag and
// the running byte total. Bytes completed after the total reaches size_limit
// are dropped and set the flag, but still advance the bit position.
// Config channel cfg_*: writes size_limit; it is always ready and should only
// be written while the block is idle.
// The result is registered, valid in the cycle after acceptance; one item is
// accepted every cycle unless the output stalls; the state sits in one register.
// An output register separates the sides: when the receiver stalls, the held
// result waits and s_tready drops until it is taken.
// Reset clears the pending byte, total and flag, and sets size_limit to all ones.
module msb_bit_field_packer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [4:0] bit_count, [20:5] code_value, [23:21] zero
    input  logic [msbp_pkg::S_TDATA_W-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] bytes_emitted, [9:2] first_byte, [17:10] second_byte,
    // [18] limit_hit, [50:19] bytes_total, [55:51] zero
    output logic [msbp_pkg::M_TDATA_W-1:0] m_tdata
);
    import msbp_pkg::*;

    localparam int RES_W = $bits(pack_result_t);

    pack_state_t         state_reg;
    pack_state_t         state_next;
    pack_result_t        result_next;
    logic [TOTAL_W-1:0]  limit_reg;
    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                s_accept;
    logic [RES_W-1:0]    res_bits;

    assign cfg_ready = 1'b1;
    assign s_tready  = ~m_tvalid_reg | m_tready;
    assign s_accept  = s_tvalid & s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    msbp_core u_core (
        .state_i      (state_reg),
        .size_limit_i (limit_reg),
        .bit_count_i  (s_tdata[COUNT_W-1:0]),
        .code_value_i (s_tdata[COUNT_W+CODE_W-1:COUNT_W]),
        .state_o      (state_next),
        .result_o     (result_next)
    );

    // Reorder the struct so the first field lands in the low bits.
    assign res_bits = {result_next.bytes_total, result_next.limit_hit,
                       result_next.second_byte, result_next.first_byte,
                       result_next.bytes_emitted};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.pending  <= '0;
            state_reg.free_pos <= FREE_EMPTY;
            state_reg.written  <= '0;
            state_reg.overflow <= 1'b0;
            limit_reg          <= LIMIT_RESET;
            m_tvalid_reg       <= 1'b0;
        end else begin
            if (cfg_valid) begin
                limit_reg <= cfg_data;
            end
            if (s_accept) begin
                state_reg    <= state_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {{(M_TDATA_W-RES_W){1'b0}}, res_bits};
        end
    end

endmodule

### tb/msb_bit_field_packer_test.sv
`timescale 1ns / 1ps

module msb_bit_field_packer_test;
    import msbp_pkg::*;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [COUNT_W-1:0] cnt;
        logic [CODE_W-1:0]  code;
        bit                typed;
        pack_result_t      want;
        logic [TOTAL_W-1:0] limit;
    } dir_row_t;

    localparam int DIR_ROWS     = 22;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 150;
    localparam int LONG_HOLD    = 64;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [31:0]          cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Predicted packer state and the size limit currently programmed.
    logic [BYTE_W-1:0]  pk_pending = '0;
    logic [FREE_W-1:0]  pk_free = FREE_EMPTY;
    logic [TOTAL_W-1:0] pk_total = '0;
    logic               pk_flag = 1'b0;
    logic [TOTAL_W-1:0] pk_limit = LIMIT_RESET;

    pack_result_t due_results[$];
    int           errors = 0;
    bit           tx_burst = 1'b0;
    int           tx_gapless = 0;
    bit           rx_hold = 1'b0;

    // Rows with a typed result start right after reset, so their values follow directly.
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_ITEM, 5'd8,  16'h00A5, 1'b1, '{2'd1, 8'hA5, 8'h00, 1'b0, 32'd1}, 32'd0},
        '{ROW_ITEM, 5'd0,  16'hFFFF, 1'b1, '{2'd0, 8'h00, 8'h00, 1'b0, 32'd1}, 32'd0},
        '{ROW_ITEM, 5'd16, 16'h1234, 1'b1, '{2'd2, 8'h12, 8'h34, 1'b0, 32'd3}, 32'd0},
        '{ROW_ITEM, 5'd31, 16'hFFFF, 1'b1, '{2'd2, 8'hFF, 8'hFF, 1'b0, 32'd5}, 32'd0},
        '{ROW_ITEM, 5'd4,  16'hFFF5, 1'b1, '{2'd0, 8'h00, 8'h00, 1'b0, 32'd5}, 32'd0},
        '{ROW_ITEM, 5'd4,  16'h000A, 1'b1, '{2'd1, 8'h5A, 8'h00, 1'b0, 32'd6}, 32'd0},
        '{ROW_ITEM, 5'd1,  16'h0001, 1'b0, '0, 32'd0},
        '{ROW_ITEM, 5'd16, 16'h8001, 1'b0, '0, 32'd0},
        '{ROW_ITEM, 5'd17, 16'h0000, 1'b0, '0, 32'd0},
        '{ROW_ITEM, 5'd15, 16'h7FFF, 1'b0, '0, 32'd0},
        '{ROW_ITEM, 5'd7,  16'h0055, 1'b0, '0, 32'd0},
        '{ROW_ITEM, 5'd9,  16'h01AA, 1'b0, '0, 32'd0},
        '{ROW_CFG,  5'd0,  16'h0000, 1'b0, '0, 32'd0},
        '{ROW_ITEM, 5'd16, 16'hBEEF, 1'b0, '0, 32'd0},
        '{ROW_ITEM, 5'd3,  16'h0005, 1'b0, '0, 32'd0},
        '{ROW_ITEM, 5'd0,  16'h0000, 1'b0, '0, 32'd0},
        '{ROW_ITEM, 5'd13, 16'h1FFF, 1'b0, '0, 32'd0},
        '{ROW_CFG,  5'd0,  16'h0000, 1'b0, '0, 32'hFFFF_FFFF},
        '{ROW_ITEM, 5'd12, 16'h0ABC, 1'b0, '0, 32'd0},
        '{ROW_ITEM, 5'd5,  16'hFFFF, 1'b0, '0, 32'd0},
        '{ROW_ITEM, 5'd16, 16'hFFFF, 1'b0, '0, 32'd0},
        '{ROW_ITEM, 5'd3,  16'h0000, 1'b0, '0, 32'd0}
    };

    msb_bit_field_packer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void emit_byte(inout pack_result_t r, input logic [BYTE_W-1:0] b);
        if (pk_total < pk_limit) begin
            if (r.bytes_emitted == 2'd0) begin
                r.first_byte = b;
            end else begin
                r.second_byte = b;
            end
            r.bytes_emitted = r.bytes_emitted + 2'd1;
            pk_total = pk_total + 32'd1;
        end else begin
            pk_flag = 1'b1;
        end
    endfunction

    function automatic pack_result_t pack_code(input logic [COUNT_W-1:0] cnt,
                                               input logic [CODE_W-1:0] code);
        pack_result_t r;
        int           n;
        int           fp;
        logic [16:0]  mask;
        logic [31:0]  x;
        r = '0;
        n = (cnt > MAX_CODE_BITS) ? MAX_CODE_BITS : int'(cnt);
        mask = (17'd1 << n) - 17'd1;
        x = {16'd0, code & mask[15:0]};
        fp = (pk_free < 4'd1 || pk_free > 4'd8) ? 8 : int'(pk_free);
        if (n < fp) begin
            fp = fp - n;
            pk_pending = pk_pending | 8'(x << fp);
        end else begin
            // The pending byte closes first; a long code may close a second one.
            n = n - fp;
            emit_byte(r, pk_pending | 8'(x >> n));
            if (n < 8) begin
                fp = 8 - n;
            end else begin
                emit_byte(r, 8'(x >> (n - 8)));
                fp = 16 - n;
            end
            pk_pending = 8'(x << fp);
        end
        pk_free = 4'(fp);
        r.limit_hit = pk_flag;
        r.bytes_total = pk_total;
        return r;
    endfunction

    task automatic send_code(input logic [COUNT_W-1:0] cnt, input logic [CODE_W-1:0] code,
                             input bit typed, input pack_result_t typed_want);
        int           gap;
        pack_result_t want;
        if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
        if (tx_gapless > 0) begin
            gap = 0;
            tx_gapless--;
        end else begin
            gap = tx_burst ? 0 : $urandom_range(0, 5);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, code, cnt};
        do @(posedge aclk); while (!s_tready);
        want = pack_code(cnt, code);
        if (typed) want = typed_want;
        due_results.push_back(want);
    endtask

    task automatic wait_results_done;
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_size_limit(input logic [TOTAL_W-1:0] value);
        wait_results_done();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        pk_limit = value;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin : rx_side
        int gap;
        bit rx_burst;
        rx_burst = 1'b0;
        forever begin
            if (rx_hold) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                rx_hold = 1'b0;
            end
            if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin : check_results
        pack_result_t got;
        pack_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.bytes_emitted = m_tdata[1:0];
            got.first_byte    = m_tdata[9:2];
            got.second_byte   = m_tdata[17:10];
            got.limit_hit     = m_tdata[18];
            got.bytes_total   = m_tdata[50:19];
            if (due_results.size() == 0) begin
                $error("result item with no expectation waiting: %h", m_tdata);
                errors++;
            end else begin
                want = due_results.pop_front();
                if (got.bytes_emitted !== want.bytes_emitted) begin
                    $error("bytes_emitted: expected %0d, got %0d",
                           want.bytes_emitted, got.bytes_emitted);
                    errors++;
                end
                if (got.first_byte !== want.first_byte) begin
                    $error("first_byte: expected %h, got %h", want.first_byte, got.first_byte);
                    errors++;
                end
                if (got.second_byte !== want.second_byte) begin
                    $error("second_byte: expected %h, got %h",
                           want.second_byte, got.second_byte);
                    errors++;
                end
                if (got.limit_hit !== want.limit_hit) begin
                    $error("limit_hit: expected %0d, got %0d", want.limit_hit, got.limit_hit);
                    errors++;
                end
                if (got.bytes_total !== want.bytes_total) begin
                    $error("bytes_total: expected %0d, got %0d",
                           want.bytes_total, got.bytes_total);
                    errors++;
                end
            end
        end
    end

    initial begin : main_flow
        logic [COUNT_W-1:0] cnt;
        logic [CODE_W-1:0]  code;
        logic [TOTAL_W-1:0] limit;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                write_size_limit(dir_rows[i].limit);
            end else begin
                send_code(dir_rows[i].cnt, dir_rows[i].code, dir_rows[i].typed,
                          dir_rows[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: limit = LIMIT_RESET;
                1: limit = '0;
                2: limit = pk_total + 32'($urandom_range(0, 20));
                default: begin
                    case ($urandom_range(0, 3))
                        0: limit = pk_total + 32'($urandom_range(0, 80));
                        1: limit = $urandom;
                        2: limit = LIMIT_RESET;
                        default: limit = pk_total;
                    endcase
                end
            endcase
            write_size_limit(limit);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // Stall the receiver while items keep coming, to fill the output side.
                if (ph == 3 && k == 20) begin
                    rx_hold = 1'b1;
                    tx_gapless = 40;
                end
                if ($urandom_range(0, 4) == 0) begin
                    cnt = 5'($urandom_range(0, 31));
                end else begin
                    cnt = 5'($urandom_range(1, 16));
                end
                code = 16'($urandom);
                send_code(cnt, code, 1'b0, '0);
            end
        end

        wait_results_done();
        repeat (8) @(posedge aclk);
        if (errors == 0 && due_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### files.f
rtl/msbp_pkg.sv
rtl/msbp_core.sv
rtl/msb_bit_field_packer.sv
tb/msb_bit_field_packer_test.sv
